@@ rtl/obb_pkg.sv @@
// Package holding the shared types and constants of the box overlap check.
package obb_pkg;

  localparam int CoordW = 24;
  localparam int TrigW  = 16;
  localparam int HalfW  = 16;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  // One pair of boxes as it travels from the front stage to the back stage.
  typedef struct packed {
    logic signed [CoordW-1:0] acx;
    logic signed [CoordW-1:0] acy;
    logic signed [TrigW-1:0]  ac;
    logic signed [TrigW-1:0]  as_;
    logic [HalfW-1:0]         ahl;
    logic [HalfW-1:0]         ahw;
    logic signed [CoordW-1:0] bcx;
    logic signed [CoordW-1:0] bcy;
    logic signed [TrigW-1:0]  bc;
    logic signed [TrigW-1:0]  bs;
    logic [HalfW-1:0]         bhl;
    logic [HalfW-1:0]         bhw;
  } pair_t;

  // Classified word: the bounding-box verdict plus the data the axis tests need.
  typedef struct packed {
    logic  bound_hit;
    pair_t pair;
  } front_word_t;

endpackage

@@ rtl/obb_front.sv @@
// Front stage: registers a pair and does the axis-aligned bounds rejection.
module obb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  obb_pkg::pair_t      in_pair,
  output logic                fw_valid,
  input  logic                fw_ready,
  output obb_pkg::front_word_t fw
);
  import obb_pkg::*;

  // Stage 1: corner offset magnitudes.
  logic        s1_valid;
  pair_t       s1_pair;
  logic [30:0] m1x, m2x, m1y, m2y, m3x, m4x, m3y, m4y;
  // Stage 2: extents and bound compare.
  logic        s2_valid;
  pair_t       s2_pair;
  logic        s2_hit;

  logic        adv1, adv2;
  logic signed [31:0] p_dx1, p_dy1, p_dx2, p_dy2, p_dx3, p_dy3, p_dx4, p_dy4;
  logic signed [40:0] axs, ays, bxs, bys;
  logic signed [40:0] aex, aey, bex, bey;

  function automatic logic [30:0] mag32(input logic signed [31:0] v);
    logic signed [31:0] a;
    a = v < 0 ? -v : v;
    return a[30:0];
  endfunction

  assign adv2 = !s2_valid || fw_ready;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;

  assign p_dx1 = 32'(in_pair.ac)  * $signed({1'b0, in_pair.ahl});
  assign p_dy1 = 32'(in_pair.as_) * $signed({1'b0, in_pair.ahl});
  assign p_dx2 = 32'(in_pair.as_) * $signed({1'b0, in_pair.ahw});
  assign p_dy2 = 32'(in_pair.ac)  * $signed({1'b0, in_pair.ahw});
  assign p_dx3 = 32'(in_pair.bc)  * $signed({1'b0, in_pair.bhl});
  assign p_dy3 = 32'(in_pair.bs)  * $signed({1'b0, in_pair.bhl});
  assign p_dx4 = 32'(in_pair.bs)  * $signed({1'b0, in_pair.bhw});
  assign p_dy4 = 32'(in_pair.bc)  * $signed({1'b0, in_pair.bhw});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1) begin
      s1_pair <= in_pair;
      m1x <= mag32(p_dx1); m1y <= mag32(p_dy1);
      m2x <= mag32(p_dx2); m2y <= mag32(p_dy2);
      m3x <= mag32(p_dx3); m3y <= mag32(p_dy3);
      m4x <= mag32(p_dx4); m4y <= mag32(p_dy4);
    end
  end

  assign axs = 41'(s1_pair.acx) <<< 15;
  assign ays = 41'(s1_pair.acy) <<< 15;
  assign bxs = 41'(s1_pair.bcx) <<< 15;
  assign bys = 41'(s1_pair.bcy) <<< 15;
  assign aex = $signed(41'(m1x) + 41'(m2x));
  assign aey = $signed(41'(m1y) + 41'(m2y));
  assign bex = $signed(41'(m3x) + 41'(m4x));
  assign bey = $signed(41'(m3y) + 41'(m4y));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_pair <= s1_pair;
      s2_hit  <= !((bxs + bex < axs - aex) || (bxs - bex > axs + aex) ||
                   (bys + bey < ays - aey) || (bys - bey > ays + aey));
    end
  end

  assign fw_valid = s2_valid;
  assign fw.bound_hit = s2_hit;
  assign fw.pair = s2_pair;
endmodule

@@ rtl/obb_queue.sv @@
// Short first-in first-out queue between the front and back stages.
module obb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  obb_pkg::front_word_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output obb_pkg::front_word_t rd_data
);
  import obb_pkg::*;

  front_word_t            slots [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr, rd_ptr;
  logic [QueuePtrW:0]     count;
  logic                   do_wr, do_rd;

  assign wr_ready = count != (QueuePtrW+1)'(QueueDepth);
  assign rd_valid = count != '0;
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueuePtrW+1)'(do_wr) - (QueuePtrW+1)'(do_rd);
    end
    if (do_wr) slots[wr_ptr] <= wr_data;
  end
endmodule

@@ rtl/obb_back.sv @@
// Back stage: four separating-axis tests in a three-step pipeline.
module obb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  obb_pkg::front_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit
);
  import obb_pkg::*;

  // Stage 1: center shift and corner offsets.
  logic               s1_valid, s1_bh;
  pair_t              s1_p;
  logic signed [24:0] s1_sx, s1_sy;
  logic signed [31:0] d1x, d1y, d2x, d2y, d3x, d3y, d4x, d4y;
  // Stage 2: projections on the four axes.
  logic               s2_valid, s2_bh;
  logic signed [41:0] sp [4];
  logic signed [48:0] o1 [4];
  logic signed [48:0] o2 [4];
  logic [HalfW-1:0]   hh [4];
  // Stage 3: result.
  logic               s3_valid, s3_hit;
  logic               adv1, adv2, adv3;
  logic [3:0]         ok;

  assign adv3 = !s3_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
    if (adv1) begin
      s1_bh <= in_word.bound_hit;
      s1_p  <= in_word.pair;
      s1_sx <= 25'(in_word.pair.bcx) - 25'(in_word.pair.acx);
      s1_sy <= 25'(in_word.pair.bcy) - 25'(in_word.pair.acy);
      d1x <= 32'(in_word.pair.ac)  * $signed({1'b0, in_word.pair.ahl});
      d1y <= 32'(in_word.pair.as_) * $signed({1'b0, in_word.pair.ahl});
      d2x <= 32'(in_word.pair.as_) * $signed({1'b0, in_word.pair.ahw});
      d2y <= -(32'(in_word.pair.ac) * $signed({1'b0, in_word.pair.ahw}));
      d3x <= 32'(in_word.pair.bc)  * $signed({1'b0, in_word.pair.bhl});
      d3y <= 32'(in_word.pair.bs)  * $signed({1'b0, in_word.pair.bhl});
      d4x <= 32'(in_word.pair.bs)  * $signed({1'b0, in_word.pair.bhw});
      d4y <= -(32'(in_word.pair.bc) * $signed({1'b0, in_word.pair.bhw}));
    end
    if (adv2) begin
      s2_bh <= s1_bh;
      sp[0] <= 42'(s1_sx) * 42'(s1_p.ac)  + 42'(s1_sy) * 42'(s1_p.as_);
      sp[1] <= 42'(s1_sx) * 42'(s1_p.as_) - 42'(s1_sy) * 42'(s1_p.ac);
      sp[2] <= 42'(s1_sx) * 42'(s1_p.bc)  + 42'(s1_sy) * 42'(s1_p.bs);
      sp[3] <= 42'(s1_sx) * 42'(s1_p.bs)  - 42'(s1_sy) * 42'(s1_p.bc);
      o1[0] <= 49'(d3x) * 49'(s1_p.ac)  + 49'(d3y) * 49'(s1_p.as_);
      o2[0] <= 49'(d4x) * 49'(s1_p.ac)  + 49'(d4y) * 49'(s1_p.as_);
      o1[1] <= 49'(d3x) * 49'(s1_p.as_) - 49'(d3y) * 49'(s1_p.ac);
      o2[1] <= 49'(d4x) * 49'(s1_p.as_) - 49'(d4y) * 49'(s1_p.ac);
      o1[2] <= 49'(d1x) * 49'(s1_p.bc)  + 49'(d1y) * 49'(s1_p.bs);
      o2[2] <= 49'(d2x) * 49'(s1_p.bc)  + 49'(d2y) * 49'(s1_p.bs);
      o1[3] <= 49'(d1x) * 49'(s1_p.bs)  - 49'(d1y) * 49'(s1_p.bc);
      o2[3] <= 49'(d2x) * 49'(s1_p.bs)  - 49'(d2y) * 49'(s1_p.bc);
      hh[0] <= s1_p.ahl;
      hh[1] <= s1_p.ahw;
      hh[2] <= s1_p.bhl;
      hh[3] <= s1_p.bhw;
    end
    if (adv3) s3_hit <= s2_bh && (&ok);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [56:0] lhs, rhs;
      logic signed [48:0] a1, a2;
      logic signed [41:0] a0;
      a0 = sp[i] < 0 ? -sp[i] : sp[i];
      a1 = o1[i] < 0 ? -o1[i] : o1[i];
      a2 = o2[i] < 0 ? -o2[i] : o2[i];
      lhs = 57'(a0) << 15;
      rhs = 57'(a1) + 57'(a2) + (57'(hh[i]) << 30);
      ok[i] = lhs <= rhs;
    end
  end

  assign out_valid = s3_valid;
  assign out_hit = s3_hit;
endmodule

@@ rtl/oriented_box_overlap_check_unit.sv @@
// Top level of the oriented box overlap check unit.
// This unit takes one pair of oriented rectangles per word and returns one
// overlap word per pair, in order. A pair passes a two-stage front part that
// rejects it on disjoint axis-aligned corner bounds, a four-entry queue, and
// a three-stage back part that runs the four separating-axis tests with
// exact full-width products. It accepts one word per cycle while results are
// taken; a word passes the five pipeline registers and the queue slot, and
// touching boxes count as overlapping.
module oriented_box_overlap_check_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [obb_pkg::CoordW-1:0] a_center_x,
  input  logic signed [obb_pkg::CoordW-1:0] a_center_y,
  input  logic signed [obb_pkg::TrigW-1:0]  a_cos,
  input  logic signed [obb_pkg::TrigW-1:0]  a_sin,
  input  logic [obb_pkg::HalfW-1:0]         a_half_len,
  input  logic [obb_pkg::HalfW-1:0]         a_half_wid,
  input  logic signed [obb_pkg::CoordW-1:0] b_center_x,
  input  logic signed [obb_pkg::CoordW-1:0] b_center_y,
  input  logic signed [obb_pkg::TrigW-1:0]  b_cos,
  input  logic signed [obb_pkg::TrigW-1:0]  b_sin,
  input  logic [obb_pkg::HalfW-1:0]         b_half_len,
  input  logic [obb_pkg::HalfW-1:0]         b_half_wid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              overlap
);
  import obb_pkg::*;

  pair_t       in_pair;
  front_word_t fw, qw;
  logic        fw_valid, fw_ready, qw_valid, qw_ready;

  // Gather the input ports into one pair word.
  assign in_pair = '{acx: a_center_x, acy: a_center_y, ac: a_cos, as_: a_sin,
                     ahl: a_half_len, ahw: a_half_wid,
                     bcx: b_center_x, bcy: b_center_y, bc: b_cos, bs: b_sin,
                     bhl: b_half_len, bhw: b_half_wid};

  obb_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_pair,
    .fw_valid, .fw_ready, .fw
  );

  // The queue lets the front keep classifying while the back is stalled.
  obb_queue u_queue (
    .clk, .rst,
    .wr_valid(fw_valid), .wr_ready(fw_ready), .wr_data(fw),
    .rd_valid(qw_valid), .rd_ready(qw_ready), .rd_data(qw)
  );

  obb_back u_back (
    .clk, .rst,
    .in_valid(qw_valid), .in_ready(qw_ready), .in_word(qw),
    .out_valid, .out_ready, .out_hit(overlap)
  );
endmodule

@@ rtl/obb_checker.sv @@
// Port-level checker for the overlap check unit and its bind statement.
module obb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overlap
);
  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(overlap))
    else $error("stalled result changed");

  // Nothing comes out in the first cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // With the output always taken, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    $past(out_ready) && out_ready && !$past(rst) |-> in_ready)
    else $error("input stalled while output drains");

  // A presented result always carries a defined verdict.
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(overlap))
    else $error("result with undefined verdict");
endmodule

bind oriented_box_overlap_check_unit obb_checker u_obb_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .overlap
);
